[src/orep_pkg.sv]
package orep_pkg;

    // Default word format: signed Q15.32 in a 48-bit word.
    localparam int WORD_BITS_DEF  = 48;
    localparam int FRAC_BITS_DEF  = 32;

    // Temperatures are unsigned Q16.16.
    localparam int TEMP_BITS      = 32;
    localparam int TEMP_FRAC_BITS = 16;

    // Width of the semidefinite tolerance register.
    localparam int TOL_BITS       = 47;

    // Latency of one fixed-point multiplier pipeline.
    localparam int MUL_LAT        = 5;

    // Result layout: ten words in tdata, two flags in tuser.
    localparam int NUM_WORDS      = 10;
    localparam int FLAG_BITS      = 2;
    localparam int FLAG_TEMP      = 0;
    localparam int FLAG_CFG       = 1;

    localparam int CFG_INDEX_BITS = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_REACTION_MOB = 2'd0,
        REG_CROSS_MOB    = 2'd1,
        REG_ENERGY_MOB   = 2'd2,
        REG_PSD_TOL      = 2'd3
    } cfg_index_t;

endpackage

[src/onsager_reaction_energy_point_core.sv]
// Channel  Dir  Handshake                 Payload
// s_       in   s_tvalid / s_tready       s_tdata: force, Tf, Ts, rate, energy rate
// m_       out  m_tvalid / m_tready       m_tdata: ten result words; m_tuser: flags
// cfg_     in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One transaction is accepted per cycle while the output register is free or taken.
// The reciprocal divider takes one stage per quotient bit; then stage B, two five-stage
// multiplier levels with stage C between them, and the output register follow.
// Reset is synchronous and active low; it clears all valid bits.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
module onsager_reaction_energy_point_core import orep_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic s_tvalid,
    output logic s_tready,
    // reaction force, fluid temperature, solid temperature, actual_rate,
    // energy transfer rate, from the lowest bit up, zero padded to bytes.
    input  logic [((3*WORD_BITS + 2*TEMP_BITS + 7) / 8) * 8 - 1:0] s_tdata,

    output logic m_tvalid,
    input  logic m_tready,
    // thermal_force, predicted_rate, predicted_energy_rate, rate_residual,
    // energy_rate_residual, reaction_entropy, energy_entropy, total_entropy,
    // quadratic_dissipation, matrix_determinant, from the lowest bit up.
    output logic [((NUM_WORDS*WORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // temperature_error, config_error, from the lowest bit up.
    output logic [FLAG_BITS-1:0] m_tuser,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [((WORD_BITS > TOL_BITS) ? WORD_BITS : TOL_BITS) - 1:0] cfg_data
);

    localparam int W        = WORD_BITS;
    localparam int NW       = TEMP_FRAC_BITS + FRAC_BITS + 1;
    localparam int DW       = (NW + 1 > W) ? NW + 1 : W;
    localparam int CW       = ((W > TOL_BITS) ? W : TOL_BITS) + 2;
    localparam int OUT_BITS = ((NUM_WORDS*W + 7) / 8) * 8;

    // Saturate a value one bit wider than the word.
    function automatic logic [W-1:0] sat_w(input logic [W:0] v);
        logic [W-1:0] r;
        if (v[W] != v[W-1]) begin
            r = v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
        return sat_w({a[W-1], a} + {b[W-1], b});
    endfunction

    function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
        return sat_w({a[W-1], a} - {b[W-1], b});
    endfunction

    // ---------------------------------------------------------------------
    // Configuration registers. Writes are always taken.
    // ---------------------------------------------------------------------
    logic [W-1:0]        l00_reg, l01_reg, l11_reg;
    logic [TOL_BITS-1:0] tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l00_reg <= '0;
            l01_reg <= '0;
            l11_reg <= '0;
            tol_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                REG_REACTION_MOB: l00_reg <= cfg_data[W-1:0];
                REG_CROSS_MOB:    l01_reg <= cfg_data[W-1:0];
                REG_ENERGY_MOB:   l11_reg <= cfg_data[W-1:0];
                REG_PSD_TOL:      tol_reg <= cfg_data[TOL_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // The determinant and the semidefinite check run freely on the registers.
    // After a write they settle through the multipliers into det_reg, and from det_reg
    // into cerr_reg; they do not stall with the output.
    logic [W-1:0]  det_p0, det_p1;
    logic [W-1:0]  det_reg;
    logic          cerr_reg;
    logic [CW-1:0] ntol, l00_x, l11_x, det_x;

    orep_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_det0 (
        .aclk(aclk), .en(1'b1), .a(l00_reg), .b(l11_reg), .p(det_p0)
    );
    orep_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_det1 (
        .aclk(aclk), .en(1'b1), .a(l01_reg), .b(l01_reg), .p(det_p1)
    );

    assign ntol  = CW'(0) - {{(CW-TOL_BITS){1'b0}}, tol_reg};
    assign l00_x = {{(CW-W){l00_reg[W-1]}}, l00_reg};
    assign l11_x = {{(CW-W){l11_reg[W-1]}}, l11_reg};
    assign det_x = {{(CW-W){det_reg[W-1]}}, det_reg};

    always_ff @(posedge aclk) begin
        det_reg  <= sat_sub(det_p0, det_p1);
        cerr_reg <= ($signed(l00_x) < $signed(ntol)) || ($signed(l11_x) < $signed(ntol))
                 || ($signed(det_x) < $signed(ntol));
    end

    // ---------------------------------------------------------------------
    // Flow control: every stage moves together whenever the output register
    // is empty or being drained.
    // ---------------------------------------------------------------------
    logic adv;
    logic m_tvalid_reg;
    logic in_take;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign in_take  = s_tvalid && adv;

    logic [W-1:0]         x_in, rr_in, er_in;
    logic [TEMP_BITS-1:0] tf_in, ts_in;
    logic                 terr_in;

    assign x_in    = s_tdata[W-1:0];
    assign tf_in   = s_tdata[W +: TEMP_BITS];
    assign ts_in   = s_tdata[W + TEMP_BITS +: TEMP_BITS];
    assign rr_in   = s_tdata[W + 2*TEMP_BITS +: W];
    assign er_in   = s_tdata[2*W + 2*TEMP_BITS +: W];
    assign terr_in = (tf_in == '0) || (ts_in == '0);

    // ---------------------------------------------------------------------
    // Stage group A: the two reciprocals, with the operands riding alongside.
    // ---------------------------------------------------------------------
    logic [NW-1:0]  inv_f, inv_s;
    logic [3*W:0]   a_out;
    logic           v_a;

    orep_recip #(.FRAC_BITS(FRAC_BITS)) u_recip_f (
        .aclk(aclk), .en(adv), .temp(tf_in), .recip(inv_f)
    );
    orep_recip #(.FRAC_BITS(FRAC_BITS)) u_recip_s (
        .aclk(aclk), .en(adv), .temp(ts_in), .recip(inv_s)
    );
    orep_delay #(.WIDTH(3*W+1), .DEPTH(NW)) u_dly_a (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .din({terr_in, er_in, rr_in, x_in}), .dout(a_out)
    );
    orep_delay #(.WIDTH(1), .DEPTH(NW)) u_vld_a (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .din(in_take), .dout(v_a)
    );

    // ---------------------------------------------------------------------
    // Stage B: energy force, the saturated difference of the reciprocals.
    // ---------------------------------------------------------------------
    logic [DW-1:0] dif;
    logic          dif_ok;
    logic [W-1:0]  e_b_reg, x_b_reg, rr_b_reg, er_b_reg;
    logic          terr_b_reg, v_b_reg;

    assign dif    = DW'(inv_f) - DW'(inv_s);
    assign dif_ok = (&dif[DW-1:W-1]) || !(|dif[DW-1:W-1]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_b_reg    <= dif_ok ? dif[W-1:0]
                        : (dif[DW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
            x_b_reg    <= a_out[W-1:0];
            rr_b_reg   <= a_out[W +: W];
            er_b_reg   <= a_out[2*W +: W];
            terr_b_reg <= a_out[3*W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_b_reg <= 1'b0;
        end else if (adv) begin
            v_b_reg <= v_a;
        end
    end

    // ---------------------------------------------------------------------
    // First multiplier level: matrix terms and the two entropy productions.
    // ---------------------------------------------------------------------
    logic [W-1:0] m_lx, m_ce, m_cx, m_le, m_re, m_ee;
    logic [4*W:0] b_out;
    logic         v_bd;

    orep_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul_lx (
        .aclk(aclk), .en(adv), .a(l00_reg), .b(x_b_reg), .p(m_lx)
    );
    orep_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul_ce (
        .aclk(aclk), .en(adv), .a(l01_reg), .b(e_b_reg), .p(m_ce)
    );
    orep_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul_cx (
        .aclk(aclk), .en(adv), .a(l01_reg), .b(x_b_reg), .p(m_cx)
    );
    orep_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul_le (
        .aclk(aclk), .en(adv), .a(l11_reg), .b(e_b_reg), .p(m_le)
    );
    orep_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul_re (
        .aclk(aclk), .en(adv), .a(x_b_reg), .b(rr_b_reg), .p(m_re)
    );
    orep_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul_ee (
        .aclk(aclk), .en(adv), .a(e_b_reg), .b(er_b_reg), .p(m_ee)
    );
    orep_delay #(.WIDTH(4*W+1), .DEPTH(MUL_LAT)) u_dly_b (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .din({terr_b_reg, er_b_reg, rr_b_reg, e_b_reg, x_b_reg}), .dout(b_out)
    );
    orep_delay #(.WIDTH(1), .DEPTH(MUL_LAT)) u_vld_b (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .din(v_b_reg), .dout(v_bd)
    );

    // ---------------------------------------------------------------------
    // Stage C: predicted rates.
    // ---------------------------------------------------------------------
    logic [W-1:0] pr_c_reg, pe_c_reg, re_c_reg, ee_c_reg;
    logic [W-1:0] x_c_reg, e_c_reg, rr_c_reg, er_c_reg;
    logic         terr_c_reg, v_c_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pr_c_reg   <= sat_add(m_lx, m_ce);
            pe_c_reg   <= sat_add(m_cx, m_le);
            re_c_reg   <= m_re;
            ee_c_reg   <= m_ee;
            x_c_reg    <= b_out[W-1:0];
            e_c_reg    <= b_out[W +: W];
            rr_c_reg   <= b_out[2*W +: W];
            er_c_reg   <= b_out[3*W +: W];
            terr_c_reg <= b_out[4*W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_c_reg <= 1'b0;
        end else if (adv) begin
            v_c_reg <= v_bd;
        end
    end

    // ---------------------------------------------------------------------
    // Second multiplier level: forces dotted with predicted rates.
    // ---------------------------------------------------------------------
    logic [W-1:0] m_xp, m_ep;
    logic [7*W:0] c_out;
    logic         v_cd;

    orep_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul_xp (
        .aclk(aclk), .en(adv), .a(x_c_reg), .b(pr_c_reg), .p(m_xp)
    );
    orep_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul_ep (
        .aclk(aclk), .en(adv), .a(e_c_reg), .b(pe_c_reg), .p(m_ep)
    );
    orep_delay #(.WIDTH(7*W+1), .DEPTH(MUL_LAT)) u_dly_c (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .din({terr_c_reg, er_c_reg, rr_c_reg, ee_c_reg, re_c_reg,
              pe_c_reg, pr_c_reg, e_c_reg}),
        .dout(c_out)
    );
    orep_delay #(.WIDTH(1), .DEPTH(MUL_LAT)) u_vld_c (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .din(v_c_reg), .dout(v_cd)
    );

    // ---------------------------------------------------------------------
    // Output register: residuals, totals, and zeroing on a bad temperature.
    // ---------------------------------------------------------------------
    logic [W-1:0]           e_d, pr_d, pe_d, re_d, ee_d, rr_d, er_d;
    logic                   terr_d;
    logic [NUM_WORDS*W-1:0] words;
    logic [OUT_BITS-1:0]    m_tdata_reg;
    logic [FLAG_BITS-1:0]   m_tuser_reg;

    assign e_d    = c_out[W-1:0];
    assign pr_d   = c_out[W +: W];
    assign pe_d   = c_out[2*W +: W];
    assign re_d   = c_out[3*W +: W];
    assign ee_d   = c_out[4*W +: W];
    assign rr_d   = c_out[5*W +: W];
    assign er_d   = c_out[6*W +: W];
    assign terr_d = c_out[7*W];

    assign words = {det_reg,
                    sat_add(m_xp, m_ep),
                    sat_add(re_d, ee_d),
                    ee_d,
                    re_d,
                    sat_sub(er_d, pe_d),
                    sat_sub(rr_d, pr_d),
                    pe_d,
                    pr_d,
                    e_d};

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= terr_d ? '0 : OUT_BITS'(words);
            m_tuser_reg[FLAG_TEMP] <= terr_d;
            m_tuser_reg[FLAG_CFG]  <= cerr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= v_cd;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[src/orep_delay.sv]
module orep_delay import orep_pkg::*; #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    // Shift line that advances only while the pipeline advances.
    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                tap_reg[i] <= '0;
            end
        end else if (en) begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

[src/orep_recip.sv]
module orep_recip import orep_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic [TEMP_BITS-1:0]                 temp,
    output logic [TEMP_FRAC_BITS+FRAC_BITS:0]    recip
);

    // Restoring division of 2^(16+F) + t/2 by t, one quotient bit per stage.
    localparam int NW = TEMP_FRAC_BITS + FRAC_BITS + 1;

    logic [TEMP_BITS-1:0] rem_reg [NW];
    logic [TEMP_BITS-1:0] div_reg [NW];
    logic [NW-1:0]        num_reg [NW];
    logic [NW-1:0]        quo_reg [NW];
    logic [NW-1:0]        num_first;

    assign num_first = {1'b1, {(NW-1){1'b0}}} + NW'(temp >> 1);

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [TEMP_BITS-1:0] rem_in;
        logic [TEMP_BITS-1:0] div_in;
        logic [NW-1:0]        num_in;
        logic [NW-1:0]        quo_in;
        logic [TEMP_BITS:0]   trial;
        logic [TEMP_BITS:0]   diff;
        logic                 ge;

        if (k == 0) begin : g_head
            assign rem_in = '0;
            assign div_in = temp;
            assign num_in = num_first;
            assign quo_in = '0;
        end else begin : g_body
            assign rem_in = rem_reg[k-1];
            assign div_in = div_reg[k-1];
            assign num_in = num_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign trial = {rem_in, num_in[NW-1]};
        assign diff  = trial - {1'b0, div_in};
        assign ge    = (trial >= {1'b0, div_in});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[TEMP_BITS-1:0] : trial[TEMP_BITS-1:0];
                div_reg[k] <= div_in;
                num_reg[k] <= num_in << 1;
                quo_reg[k] <= {quo_in[NW-2:0], ge};
            end
        end
    end

    assign recip = quo_reg[NW-1];

endmodule

[src/orep_mul.sv]
module orep_mul import orep_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [WORD_BITS-1:0] a,
    input  logic [WORD_BITS-1:0] b,
    output logic [WORD_BITS-1:0] p
);

    // Sign-magnitude product split into four half-width partial products,
    // rounded half away from zero and saturated to the word.
    localparam int W  = WORD_BITS;
    localparam int H  = (W + 1) / 2;
    localparam int PW = 4 * H;

    logic [W-1:0]    amag_reg, bmag_reg;
    logic [2*H-1:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [PW-1:0]   sum_reg;
    logic [W-1:0]    qmag_reg;
    logic [W-1:0]    p_reg;
    logic            neg1_reg, neg2_reg, neg3_reg, neg4_reg;

    logic [2*H-1:0]  apad, bpad;
    logic [PW-1:0]   rnd, shd, lim;

    assign apad = (2*H)'(amag_reg);
    assign bpad = (2*H)'(bmag_reg);
    assign rnd  = sum_reg + (PW'(1) << (FRAC_BITS - 1));
    assign shd  = rnd >> FRAC_BITS;
    assign lim  = neg3_reg ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));

    always_ff @(posedge aclk) begin
        if (en) begin
            amag_reg <= a[W-1] ? W'(-a) : a;
            bmag_reg <= b[W-1] ? W'(-b) : b;
            neg1_reg <= a[W-1] ^ b[W-1];

            p00_reg  <= (2*H)'(apad[H-1:0]) * (2*H)'(bpad[H-1:0]);
            p01_reg  <= (2*H)'(apad[H-1:0]) * (2*H)'(bpad[2*H-1:H]);
            p10_reg  <= (2*H)'(apad[2*H-1:H]) * (2*H)'(bpad[H-1:0]);
            p11_reg  <= (2*H)'(apad[2*H-1:H]) * (2*H)'(bpad[2*H-1:H]);
            neg2_reg <= neg1_reg;

            sum_reg  <= (PW'(p11_reg) << (2*H)) + (PW'(p01_reg) << H)
                      + (PW'(p10_reg) << H) + PW'(p00_reg);
            neg3_reg <= neg2_reg;

            qmag_reg <= (shd > lim) ? lim[W-1:0] : shd[W-1:0];
            neg4_reg <= neg3_reg;

            p_reg    <= neg4_reg ? W'(-qmag_reg) : qmag_reg;
        end
    end

    assign p = p_reg;

endmodule

[src/orep_checker.sv]
module orep_checker import orep_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input logic                                          aclk,
    input logic                                          aresetn,
    input logic                                          s_tready,
    input logic                                          m_tvalid,
    input logic                                          m_tready,
    input logic [((NUM_WORDS*WORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    input logic [FLAG_BITS-1:0]                          m_tuser
);

    // A held result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A bad temperature zeroes every result word.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[FLAG_TEMP] |-> m_tdata == '0)
        else $error("temperature error with nonzero words");

    // An empty output register never holds back the input.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Reset empties the output.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind onsager_reaction_energy_point_core orep_checker #(.WORD_BITS(WORD_BITS)) u_orep_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
